FILE: sv/tlbh_pkg.sv
// Shared types and codes for the two-level TLB hierarchy.
`timescale 1ns / 1ps

package tlbh_pkg;

  // Command codes carried by a request.
  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_FILL   = 2'd1;
  localparam logic [1:0] CMD_FLUSH  = 2'd2;

  // Flush targets.
  localparam logic [1:0] TGT_INST_L1 = 2'd0;
  localparam logic [1:0] TGT_DATA_L1 = 2'd1;
  localparam logic [1:0] TGT_L2      = 2'd2;

  typedef enum logic [2:0] {
    ST_L1_HIT  = 3'd0,
    ST_L2_HIT  = 3'd1,
    ST_MISS    = 3'd2,
    ST_FILLED  = 3'd3,
    ST_FLUSHED = 3'd4
  } status_e;

  // Update controls for one L1 array.
  typedef struct packed {
    logic wr;     // write the entry at the index (valid, tag, page)
    logic inv;    // clear the valid bit at the index
    logic flush;  // clear every valid bit
  } l1_ctrl_t;

endpackage

FILE: sv/tlbh_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tlbh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/tlbh_l1.sv
// Direct-mapped L1 TLB array held in flip-flops with one shared index port.
`timescale 1ns / 1ps

module tlbh_l1 #(
  parameter int LINES    = 16,
  parameter int TAG_BITS = 32,
  parameter int PPN_BITS = 20
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tlbh_pkg::l1_ctrl_t       ctrl_i,
  input  logic [$clog2(LINES)-1:0] idx_i,
  input  logic [TAG_BITS-1:0]      wr_tag_i,
  input  logic [PPN_BITS-1:0]      wr_page_i,
  output logic                     rd_valid_o,
  output logic [TAG_BITS-1:0]      rd_tag_o,
  output logic [PPN_BITS-1:0]      rd_page_o
);

  logic [LINES-1:0]    valid_q;
  logic [LINES-1:0]    valid_d;
  logic [TAG_BITS-1:0] tag_q  [LINES];
  logic [PPN_BITS-1:0] page_q [LINES];

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.flush) begin
      valid_d = '0;
    end else if (ctrl_i.wr) begin
      valid_d[idx_i] = 1'b1;
    end else if (ctrl_i.inv) begin
      valid_d[idx_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      tag_q[idx_i]  <= wr_tag_i;
      page_q[idx_i] <= wr_page_i;
    end
  end

  assign rd_valid_o = valid_q[idx_i];
  assign rd_tag_o   = tag_q[idx_i];
  assign rd_page_o  = page_q[idx_i];

endmodule

FILE: sv/two_level_tlb_hierarchy_core.sv
// Top level of the two-level TLB hierarchy: request stage, lookup logic and result register.
`timescale 1ns / 1ps

// Two-level TLB: direct-mapped instruction L1, data L1 and shared L2.
// Requests enter on the in_* channel (in_valid_i / in_stall_o) and carry a
// command: a lookup, a fill with the page-walk result, or a flush of one TLB.
// Every request produces exactly one result on the out_* channel
// (out_valid_o / out_stall_i) with a status, a physical page and the offset.
// A request is registered in the request stage and then in the result
// register. The accepting edge registers the request and starts the read
// of the L2 tag/page memory; the edge at which the request stage drains
// evaluates the L1 and L2 compare, updates the arrays and loads the result
// register. Throughput is one request per cycle while the receiver does not
// stall, as the request stage takes a new request in the cycle it drains.
// A fill to the L2 line that the next request reads is forwarded around
// the memory. While the receiver stalls, the result register holds; one
// more request is still taken into the request stage, after which
// in_stall_o rises until the result is taken. Reset clears all valid bits
// at once (they live in flip-flops), so no clearing pass is needed and
// requests are taken right after reset. L1_LINES and L2_LINES must be
// powers of two.
module two_level_tlb_hierarchy_core #(
  parameter int L1_LINES = 16,
  parameter int L2_LINES = 64,
  parameter int VPN_BITS = 36,
  parameter int PPN_BITS = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Request channel.
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          cmd_i,
  input  logic [VPN_BITS-1:0] vpn_i,
  input  logic                is_instruction_i,
  input  logic [11:0]         page_offset_i,
  input  logic [PPN_BITS-1:0] walk_page_i,
  input  logic [1:0]          flush_target_i,
  // Result channel.
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          status_o,
  output logic [PPN_BITS-1:0] phys_page_o,
  output logic [11:0]         phys_offset_o
);

  localparam int L1_IB    = $clog2(L1_LINES);
  localparam int L2_IB    = $clog2(L2_LINES);
  localparam int L1_TAG_W = VPN_BITS - L1_IB;
  localparam int L2_TAG_W = VPN_BITS - L2_IB;
  localparam int L2_ENT_W = L2_TAG_W + PPN_BITS;

  // Handshake control.
  logic accept;
  logic out_load_ok;
  logic s1_fire;

  // Request stage.
  logic                s1_valid_q;
  logic [1:0]          s1_cmd_q;
  logic [VPN_BITS-1:0] s1_vpn_q;
  logic                s1_inst_q;
  logic [11:0]         s1_offset_q;
  logic [PPN_BITS-1:0] s1_walk_q;
  logic [1:0]          s1_target_q;

  // L2 forwarding of a fill that lands in the same cycle as the memory read.
  logic                fwd_valid_q;
  logic                fwd_valid_d;
  logic [L2_ENT_W-1:0] fwd_data_q;
  logic                fwd_hit;

  // L2 state and lookup.
  logic [L2_LINES-1:0] l2_valid_q;
  logic [L2_LINES-1:0] l2_valid_d;
  logic [L2_ENT_W-1:0] l2_rdata;
  logic [L2_ENT_W-1:0] l2_entry;
  logic [L2_IB-1:0]    l2_idx;
  logic [L2_TAG_W-1:0] l2_tag;
  logic                l2_ent_valid;
  logic                l2_hit;
  logic                l2_we;

  // L1 lookup and victim selection.
  logic [L1_IB-1:0]    l1_idx;
  logic [L1_TAG_W-1:0] l1_tag;
  logic [VPN_BITS-1:0] old_vpn;
  logic [L1_IB-1:0]    vic_idx;
  logic [L1_TAG_W-1:0] vic_tag;
  logic                l1_hit;
  logic                own_valid;
  logic [L1_TAG_W-1:0] own_tag;
  logic [PPN_BITS-1:0] own_page;
  logic                oth_valid;
  logic [L1_TAG_W-1:0] oth_tag;
  logic                vic_kill;
  logic                own_wr;
  logic [PPN_BITS-1:0] own_wr_page;

  logic                    il1_valid;
  logic [L1_TAG_W-1:0]     il1_tag;
  logic [PPN_BITS-1:0]     il1_page;
  logic [L1_IB-1:0]        il1_idx;
  tlbh_pkg::l1_ctrl_t      il1_ctrl;
  logic                    dl1_valid;
  logic [L1_TAG_W-1:0]     dl1_tag;
  logic [PPN_BITS-1:0]     dl1_page;
  logic [L1_IB-1:0]        dl1_idx;
  tlbh_pkg::l1_ctrl_t      dl1_ctrl;

  // Result.
  tlbh_pkg::status_e   res_status;
  logic [PPN_BITS-1:0] res_page;
  logic                out_valid_q;
  tlbh_pkg::status_e   out_status_q;
  logic [PPN_BITS-1:0] out_page_q;
  logic [11:0]         out_offset_q;

  // The result register loads when empty or when its result leaves; the
  // request stage then drains into it and can take the next request.
  assign out_load_ok = !out_valid_q || !out_stall_i;
  assign s1_fire     = s1_valid_q && out_load_ok;
  assign in_stall_o  = s1_valid_q && !out_load_ok;
  assign accept      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q    <= cmd_i;
      s1_vpn_q    <= vpn_i;
      s1_inst_q   <= is_instruction_i;
      s1_offset_q <= page_offset_i;
      s1_walk_q   <= walk_page_i;
      s1_target_q <= flush_target_i;
    end
  end

  // Field split of the registered request.
  assign l2_idx  = s1_vpn_q[L2_IB-1:0];
  assign l2_tag  = s1_vpn_q[VPN_BITS-1:L2_IB];
  assign l1_idx  = s1_vpn_q[L1_IB-1:0];
  assign l1_tag  = s1_vpn_q[VPN_BITS-1:L1_IB];

  // L2 tag and page memory; valid bits are kept in flip-flops below.
  assign l2_we = s1_fire && (s1_cmd_q == tlbh_pkg::CMD_FILL);

  tlbh_ram #(
    .WIDTH (L2_ENT_W),
    .DEPTH (L2_LINES)
  ) u_l2_ram (
    .clk_i   (clk_i),
    .we_i    (l2_we),
    .waddr_i (l2_idx),
    .wdata_i ({l2_tag, s1_walk_q}),
    .re_i    (accept),
    .raddr_i (vpn_i[L2_IB-1:0]),
    .rdata_o (l2_rdata)
  );

  // The memory returns the old contents when a fill writes the line being
  // read in the same cycle, so the fill data is captured and used instead.
  assign fwd_hit = l2_we && (vpn_i[L2_IB-1:0] == l2_idx);

  always_comb begin
    fwd_valid_d = fwd_valid_q;
    if (accept) begin
      fwd_valid_d = fwd_hit;
    end else if (s1_fire) begin
      fwd_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= fwd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && fwd_hit) begin
      fwd_data_q <= {l2_tag, s1_walk_q};
    end
  end

  assign l2_entry     = fwd_valid_q ? fwd_data_q : l2_rdata;
  assign l2_ent_valid = l2_valid_q[l2_idx];
  assign l2_hit       = l2_ent_valid && (l2_entry[L2_ENT_W-1:PPN_BITS] == l2_tag);

  always_comb begin
    l2_valid_d = l2_valid_q;
    if (s1_fire) begin
      if (s1_cmd_q == tlbh_pkg::CMD_FILL) begin
        l2_valid_d[l2_idx] = 1'b1;
      end else if ((s1_cmd_q == tlbh_pkg::CMD_FLUSH) && (s1_target_q == tlbh_pkg::TGT_L2)) begin
        l2_valid_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l2_valid_q <= '0;
    end else begin
      l2_valid_q <= l2_valid_d;
    end
  end

  // The translation being evicted from L2, rebuilt from its tag and index.
  // Its entry in the other L1 is looked up at the same time as the own L1.
  assign old_vpn = {l2_entry[L2_ENT_W-1:PPN_BITS], l2_idx};
  assign vic_idx = old_vpn[L1_IB-1:0];
  assign vic_tag = old_vpn[VPN_BITS-1:L1_IB];

  // Each L1 is read at one index: its own lookup index when it serves the
  // access kind, otherwise the victim index.
  assign il1_idx = s1_inst_q ? l1_idx : vic_idx;
  assign dl1_idx = s1_inst_q ? vic_idx : l1_idx;

  assign own_valid = s1_inst_q ? il1_valid : dl1_valid;
  assign own_tag   = s1_inst_q ? il1_tag   : dl1_tag;
  assign own_page  = s1_inst_q ? il1_page  : dl1_page;
  assign oth_valid = s1_inst_q ? dl1_valid : il1_valid;
  assign oth_tag   = s1_inst_q ? dl1_tag   : il1_tag;

  assign l1_hit = own_valid && (own_tag == l1_tag);

  // The own L1 is written by a fill and refilled by an L2 hit.
  always_comb begin
    own_wr      = 1'b0;
    own_wr_page = s1_walk_q;
    case (s1_cmd_q)
      tlbh_pkg::CMD_LOOKUP: begin
        own_wr      = !l1_hit && l2_hit;
        own_wr_page = l2_entry[PPN_BITS-1:0];
      end
      tlbh_pkg::CMD_FILL: begin
        own_wr = 1'b1;
      end
      default: begin
        own_wr = 1'b0;
      end
    endcase
  end

  assign vic_kill = (s1_cmd_q == tlbh_pkg::CMD_FILL) && l2_ent_valid &&
                    oth_valid && (oth_tag == vic_tag);

  always_comb begin
    il1_ctrl.wr    = s1_fire && s1_inst_q && own_wr;
    il1_ctrl.inv   = s1_fire && !s1_inst_q && vic_kill;
    il1_ctrl.flush = s1_fire && (s1_cmd_q == tlbh_pkg::CMD_FLUSH) &&
                     (s1_target_q == tlbh_pkg::TGT_INST_L1);
    dl1_ctrl.wr    = s1_fire && !s1_inst_q && own_wr;
    dl1_ctrl.inv   = s1_fire && s1_inst_q && vic_kill;
    dl1_ctrl.flush = s1_fire && (s1_cmd_q == tlbh_pkg::CMD_FLUSH) &&
                     (s1_target_q == tlbh_pkg::TGT_DATA_L1);
  end

  tlbh_l1 #(
    .LINES    (L1_LINES),
    .TAG_BITS (L1_TAG_W),
    .PPN_BITS (PPN_BITS)
  ) u_inst_l1 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (il1_ctrl),
    .idx_i      (il1_idx),
    .wr_tag_i   (l1_tag),
    .wr_page_i  (own_wr_page),
    .rd_valid_o (il1_valid),
    .rd_tag_o   (il1_tag),
    .rd_page_o  (il1_page)
  );

  tlbh_l1 #(
    .LINES    (L1_LINES),
    .TAG_BITS (L1_TAG_W),
    .PPN_BITS (PPN_BITS)
  ) u_data_l1 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (dl1_ctrl),
    .idx_i      (dl1_idx),
    .wr_tag_i   (l1_tag),
    .wr_page_i  (own_wr_page),
    .rd_valid_o (dl1_valid),
    .rd_tag_o   (dl1_tag),
    .rd_page_o  (dl1_page)
  );

  // Result selection. Unknown commands report a miss and change nothing.
  always_comb begin
    res_status = tlbh_pkg::ST_MISS;
    res_page   = '0;
    case (s1_cmd_q)
      tlbh_pkg::CMD_LOOKUP: begin
        if (l1_hit) begin
          res_status = tlbh_pkg::ST_L1_HIT;
          res_page   = own_page;
        end else if (l2_hit) begin
          res_status = tlbh_pkg::ST_L2_HIT;
          res_page   = l2_entry[PPN_BITS-1:0];
        end
      end
      tlbh_pkg::CMD_FILL: begin
        res_status = tlbh_pkg::ST_FILLED;
        res_page   = s1_walk_q;
      end
      tlbh_pkg::CMD_FLUSH: begin
        res_status = tlbh_pkg::ST_FLUSHED;
      end
      default: begin
        res_status = tlbh_pkg::ST_MISS;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load_ok) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_status_q <= res_status;
      out_page_q   <= res_page;
      out_offset_q <= s1_offset_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign phys_page_o   = out_page_q;
  assign phys_offset_o = out_offset_q;

`ifndef SYNTHESIS
  // Forwarded L2 data only ever belongs to a request held in the request stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_valid_q |-> s1_valid_q)
    else $error("L2 forward entry without a pending request");

  // A fill leaves its L2 line valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    l2_we |=> l2_valid_q[$past(l2_idx)])
    else $error("L2 line not valid after fill");

  // A flush of the L2 leaves no valid L2 line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && (s1_cmd_q == tlbh_pkg::CMD_FLUSH) && (s1_target_q == tlbh_pkg::TGT_L2)
    |=> (l2_valid_q == '0))
    else $error("L2 valid bits remain after flush");

  // A request leaving the request stage always shows up as a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("request lost between stage and result register");

  // The two L1 arrays are never both written by one request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(il1_ctrl.wr && dl1_ctrl.wr))
    else $error("both L1 arrays written by one request");
`endif

endmodule
